>>> sv/gia_pkg.sv
// Shared types, codes and constants of the greedy IoU association unit.
package gia_pkg;

    localparam int IDX_W      = 5;
    localparam int IDX_N      = 1 << IDX_W;
    localparam int COORD_W    = 16;
    localparam int BOX_W      = 4 * COORD_W;
    localparam int IOU_W      = 17;
    localparam int OVL_W      = 16;
    localparam int PAIR_AW    = 2 * IDX_W;
    localparam int DIV_STEPS  = IOU_W;
    localparam int DEF_MAX_DETECTIONS = 32;
    localparam int DEF_MAX_TRACKS     = 32;
    localparam logic [IOU_W-1:0] DEF_IOU_THRESHOLD = 17'd19661;

    typedef enum logic [1:0] {
        OP_LOAD_DET = 2'd0,
        OP_LOAD_TRK = 2'd1,
        OP_RUN      = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_MATCH = 2'd0,
        KIND_UDET  = 2'd1,
        KIND_UTRK  = 2'd2,
        KIND_EMPTY = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRD,
        ST_CDIFF,
        ST_CMUL,
        ST_CUNI,
        ST_CDIV,
        ST_CWR,
        ST_SRD,
        ST_SCMP,
        ST_SDEC,
        ST_UDET,
        ST_UTRK,
        ST_FIN
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [BOX_W-1:0] box;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qif;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] det;
        logic [IDX_W-1:0] trk;
        logic [OVL_W-1:0] ovl;
        logic             ovf;
    } t_res;

endpackage

>>> sv/greedy_iou_association_unit.sv
// Top level of the greedy IoU association unit.
//
// Input stream: tuser carries the operation (load detection, load track, run),
// tdata the box edges. Loads go into a two-entry command queue and are written
// to the box stores from the queue; loads past capacity are dropped and
// flagged on the results of the frame's run. Unknown operations are dropped.
// A run builds the IoU table for every detection/track pair with the
// bit-per-cycle divider, then scans the table for every pick, skipping used
// pairs and reading the table memory through its registered port. Results
// follow in pick order, then unmatched detections and unmatched tracks, with
// tlast on the final one; the run ends with counts and flags cleared.
// A result is released one slot behind its production so tlast can be set;
// the output register lets the engine continue while the receiver stalls,
// and the engine waits when both the pending and output slots are full.
// Users must write the threshold register with i_cfg_wen only while idle; unenforced.
// Synchronous active-low reset empties the queue, clears counts and output;
// box and table stores are not cleared and are only read after being written.
module greedy_iou_association_unit #(
    parameter int MAX_DETECTIONS = gia_pkg::DEF_MAX_DETECTIONS,
    parameter int MAX_TRACKS     = gia_pkg::DEF_MAX_TRACKS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [1:0]                 i_s_tuser,  // operation
    input  logic [63:0]                i_s_tdata,  // left_x, top_y, right_x, bottom_y
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [1:0]                 o_m_tuser,  // kind
    output logic [31:0]                o_m_tdata,  // det_index, trk_index, overlap, overflow
    output logic                       o_m_tlast,
    input  logic                       i_cfg_wen,
    input  logic [gia_pkg::IOU_W-1:0]  i_cfg_wdata
);
    import gia_pkg::*;

    logic [IOU_W-1:0] r_thr;
    t_cmd in_cmd;
    t_qif q;
    logic pop;
    t_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= DEF_IOU_THRESHOLD;
        end else if (i_cfg_wen) begin
            r_thr <= i_cfg_wdata;
        end
    end

    assign in_cmd.op  = t_op'(i_s_tuser);
    assign in_cmd.box = i_s_tdata;

    gia_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_s_tvalid), .o_ready(o_s_tready),
        .i_cmd(in_cmd), .o_q(q), .i_pop(pop)
    );

    gia_back #(.MAX_DETECTIONS(MAX_DETECTIONS), .MAX_TRACKS(MAX_TRACKS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q(q), .o_pop(pop), .i_thr(r_thr),
        .o_valid(o_m_tvalid), .i_ready(i_m_tready), .o_res(res), .o_last(o_m_tlast)
    );

    assign o_m_tuser = res.kind;
    assign o_m_tdata = {5'b0, res.ovf, res.ovl, res.trk, res.det};

`ifndef SYNTHESIS
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_EMPTY |-> o_m_tlast)
        else $error("empty-frame result without tlast");
    a_match_meets_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_MATCH
        |-> ({1'b0, o_m_tdata[25:10]} >= r_thr) || (o_m_tdata[25:10] == 16'hFFFF))
        else $error("match below threshold");
    a_reset_clears_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");
`endif
endmodule

>>> sv/gia_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gia_ram #(
    parameter int WIDTH = 64,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [1 << AW];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/gia_front.sv
// Input side: accepts transactions, drops unknown operations, queues commands.
module gia_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  gia_pkg::t_cmd         i_cmd,
    output gia_pkg::t_qif         o_q,
    input  logic                  i_pop
);
    import gia_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_fill, n_fill;
    logic       push;
    logic       pop;

    assign o_ready = (r_fill != 2'd2);
    assign push    = i_valid && o_ready && (i_cmd.op != OP_NONE);
    assign pop     = i_pop && (r_fill != 2'd0);

    always_comb begin
        n_wptr = push ? ~r_wptr : r_wptr;
        n_rptr = pop ? ~r_rptr : r_rptr;
        n_fill = r_fill + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
        if (push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    assign o_q.valid = (r_fill != 2'd0);
    assign o_q.cmd   = r_slot[r_rptr];
endmodule

>>> sv/gia_back.sv
// Execution side: box stores, IoU table build, greedy pick and result output.
module gia_back #(
    parameter int MAX_DETECTIONS = gia_pkg::DEF_MAX_DETECTIONS,
    parameter int MAX_TRACKS     = gia_pkg::DEF_MAX_TRACKS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gia_pkg::t_qif               i_q,
    output logic                        o_pop,
    input  logic [gia_pkg::IOU_W-1:0]   i_thr,
    output logic                        o_valid,
    input  logic                        i_ready,
    output gia_pkg::t_res               o_res,
    output logic                        o_last
);
    import gia_pkg::*;

    localparam int DCW = $clog2(MAX_DETECTIONS + 1);
    localparam int TCW = $clog2(MAX_TRACKS + 1);

    t_state r_state, n_state;

    logic [DCW-1:0]   r_det_cnt;
    logic [TCW-1:0]   r_trk_cnt;
    logic [IDX_N-1:0] r_det_used, r_trk_used;
    logic             r_drop;
    logic [IDX_W:0]   r_d, r_t;

    logic [BOX_W-1:0] det_q, trk_q;
    logic [IOU_W-1:0] ovl_q;

    logic signed [COORD_W:0]     r_wa, r_ha, r_wb, r_hb;
    logic [COORD_W-1:0]          r_iw, r_ih;
    logic signed [2*COORD_W+1:0] r_area_a, r_area_b;
    logic [2*COORD_W-1:0]        r_inter;
    logic signed [2*COORD_W+3:0] r_uni;
    logic [2*COORD_W+4:0]        r_rem;
    logic [IOU_W-1:0]            r_q;
    logic [IDX_W-1:0]            r_dcnt;

    logic             r_found;
    logic [IDX_W-1:0] r_bd, r_bt;
    logic [IOU_W-1:0] r_bv;

    t_res r_pend;
    logic r_pend_v;
    t_res r_out;
    logic r_out_v;
    logic r_out_last;

    logic out_free, can_put, put, fin_push;
    t_res put_res;
    logic det_we, trk_we, ovl_we;
    logic pair_last_t, pair_end, skip, is_match, div_ge;
    logic [IOU_W-1:0] iou_val;

    // coordinate slices of the two boxes read this cycle
    logic signed [COORD_W-1:0] al, at, ar, ab, bl, bt, br, bb;
    logic signed [COORD_W-1:0] mn_r, mx_l, mn_b, mx_t;
    logic signed [COORD_W:0]   iw_s, ih_s;

    gia_ram #(.WIDTH(BOX_W), .AW(IDX_W)) u_det_ram (
        .i_clk(i_clk), .i_we(det_we), .i_waddr(IDX_W'(r_det_cnt)),
        .i_wdata(i_q.cmd.box), .i_raddr(r_d[IDX_W-1:0]), .o_rdata(det_q)
    );
    gia_ram #(.WIDTH(BOX_W), .AW(IDX_W)) u_trk_ram (
        .i_clk(i_clk), .i_we(trk_we), .i_waddr(IDX_W'(r_trk_cnt)),
        .i_wdata(i_q.cmd.box), .i_raddr(r_t[IDX_W-1:0]), .o_rdata(trk_q)
    );
    gia_ram #(.WIDTH(IOU_W), .AW(PAIR_AW)) u_ovl_ram (
        .i_clk(i_clk), .i_we(ovl_we),
        .i_waddr({r_d[IDX_W-1:0], r_t[IDX_W-1:0]}), .i_wdata(iou_val),
        .i_raddr({r_d[IDX_W-1:0], r_t[IDX_W-1:0]}), .o_rdata(ovl_q)
    );

    assign al = det_q[COORD_W-1:0];
    assign at = det_q[2*COORD_W-1:COORD_W];
    assign ar = det_q[3*COORD_W-1:2*COORD_W];
    assign ab = det_q[4*COORD_W-1:3*COORD_W];
    assign bl = trk_q[COORD_W-1:0];
    assign bt = trk_q[2*COORD_W-1:COORD_W];
    assign br = trk_q[3*COORD_W-1:2*COORD_W];
    assign bb = trk_q[4*COORD_W-1:3*COORD_W];

    assign mn_r = (ar < br) ? ar : br;
    assign mx_l = (al > bl) ? al : bl;
    assign mn_b = (ab < bb) ? ab : bb;
    assign mx_t = (at > bt) ? at : bt;
    assign iw_s = {mn_r[COORD_W-1], mn_r} - {mx_l[COORD_W-1], mx_l};
    assign ih_s = {mn_b[COORD_W-1], mn_b} - {mx_t[COORD_W-1], mx_t};

    assign out_free    = !r_out_v || i_ready;
    assign can_put     = !r_pend_v || out_free;
    assign pair_last_t = (r_t + 1'b1) == (IDX_W+1)'(r_trk_cnt);
    assign pair_end    = pair_last_t && ((r_d + 1'b1) == (IDX_W+1)'(r_det_cnt));
    assign skip        = r_det_used[r_d[IDX_W-1:0]] || r_trk_used[r_t[IDX_W-1:0]];
    assign is_match    = r_found && (r_bv >= i_thr);
    assign div_ge      = r_rem >= {1'b0, r_uni};
    // non-positive union gives zero
    assign iou_val     = (!r_uni[2*COORD_W+3] && (r_uni != '0)) ? r_q : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q.valid && i_q.cmd.op == OP_RUN) begin
                    if (r_det_cnt == '0 && r_trk_cnt == '0) begin
                        n_state = ST_FIN;
                    end else if (r_det_cnt == '0 || r_trk_cnt == '0) begin
                        n_state = ST_UDET;
                    end else begin
                        n_state = ST_CRD;
                    end
                end
            end
            ST_CRD:   n_state = ST_CDIFF;
            ST_CDIFF: n_state = ST_CMUL;
            ST_CMUL:  n_state = ST_CUNI;
            ST_CUNI:  n_state = ST_CDIV;
            ST_CDIV: begin
                if (r_dcnt == IDX_W'(DIV_STEPS - 1)) n_state = ST_CWR;
            end
            ST_CWR:  n_state = pair_end ? ST_SRD : ST_CRD;
            ST_SRD: begin
                if (!skip) n_state = ST_SCMP;
                else if (pair_end) n_state = ST_SDEC;
            end
            ST_SCMP: n_state = pair_end ? ST_SDEC : ST_SRD;
            ST_SDEC: begin
                if (!is_match) n_state = ST_UDET;
                else if (can_put) n_state = ST_SRD;
            end
            ST_UDET: begin
                if (r_d >= (IDX_W+1)'(r_det_cnt)) n_state = ST_UTRK;
            end
            ST_UTRK: begin
                if (r_t >= (IDX_W+1)'(r_trk_cnt)) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        det_we   = 1'b0;
        trk_we   = 1'b0;
        ovl_we   = 1'b0;
        put      = 1'b0;
        fin_push = 1'b0;
        put_res  = '{kind: KIND_EMPTY, det: '0, trk: '0, ovl: '0, ovf: r_drop};
        case (r_state)
            ST_IDLE: begin
                o_pop  = i_q.valid;
                det_we = i_q.valid && i_q.cmd.op == OP_LOAD_DET
                         && r_det_cnt < DCW'(MAX_DETECTIONS);
                trk_we = i_q.valid && i_q.cmd.op == OP_LOAD_TRK
                         && r_trk_cnt < TCW'(MAX_TRACKS);
                put    = i_q.valid && i_q.cmd.op == OP_RUN
                         && r_det_cnt == '0 && r_trk_cnt == '0;
            end
            ST_CWR: ovl_we = 1'b1;
            ST_SDEC: begin
                put          = is_match && can_put;
                put_res.kind = KIND_MATCH;
                put_res.det  = r_bd;
                put_res.trk  = r_bt;
                put_res.ovl  = r_bv[IOU_W-1] ? {OVL_W{1'b1}} : r_bv[OVL_W-1:0];
            end
            ST_UDET: begin
                put = (r_d < (IDX_W+1)'(r_det_cnt)) && !r_det_used[r_d[IDX_W-1:0]]
                      && can_put;
                put_res.kind = KIND_UDET;
                put_res.det  = r_d[IDX_W-1:0];
            end
            ST_UTRK: begin
                put = (r_t < (IDX_W+1)'(r_trk_cnt)) && !r_trk_used[r_t[IDX_W-1:0]]
                      && can_put;
                put_res.kind = KIND_UTRK;
                put_res.trk  = r_t[IDX_W-1:0];
            end
            ST_FIN: fin_push = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_det_cnt  <= '0;
            r_trk_cnt  <= '0;
            r_det_used <= '0;
            r_trk_used <= '0;
            r_drop     <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_state <= n_state;

            // output slot: the pending result moves out once its successor is known
            if (fin_push) begin
                r_out      <= r_pend;
                r_out_last <= 1'b1;
                r_out_v    <= 1'b1;
            end else if (put && r_pend_v) begin
                r_out      <= r_pend;
                r_out_last <= 1'b0;
                r_out_v    <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
            if (put) begin
                r_pend   <= put_res;
                r_pend_v <= 1'b1;
            end

            case (r_state)
                ST_IDLE: begin
                    if (det_we) r_det_cnt <= r_det_cnt + 1'b1;
                    if (trk_we) r_trk_cnt <= r_trk_cnt + 1'b1;
                    if (i_q.valid && !det_we && !trk_we && i_q.cmd.op != OP_RUN) begin
                        r_drop <= 1'b1;
                    end
                    r_d     <= '0;
                    r_t     <= '0;
                    r_found <= 1'b0;
                end
                ST_CDIFF: begin
                    r_wa <= {ar[COORD_W-1], ar} - {al[COORD_W-1], al};
                    r_ha <= {ab[COORD_W-1], ab} - {at[COORD_W-1], at};
                    r_wb <= {br[COORD_W-1], br} - {bl[COORD_W-1], bl};
                    r_hb <= {bb[COORD_W-1], bb} - {bt[COORD_W-1], bt};
                    r_iw <= iw_s[COORD_W] ? '0 : iw_s[COORD_W-1:0];
                    r_ih <= ih_s[COORD_W] ? '0 : ih_s[COORD_W-1:0];
                end
                ST_CMUL: begin
                    r_area_a <= r_wa * r_ha;
                    r_area_b <= r_wb * r_hb;
                    r_inter  <= r_iw * r_ih;
                end
                ST_CUNI: begin
                    r_uni  <= {{2{r_area_a[2*COORD_W+1]}}, r_area_a}
                              + {{2{r_area_b[2*COORD_W+1]}}, r_area_b}
                              - {4'b0, r_inter};
                    r_rem  <= {5'b0, r_inter};
                    r_q    <= '0;
                    r_dcnt <= '0;
                end
                ST_CDIV: begin
                    // restoring division, one quotient bit per cycle
                    r_q    <= {r_q[IOU_W-2:0], div_ge};
                    r_rem  <= (div_ge ? r_rem - {1'b0, r_uni} : r_rem) << 1;
                    r_dcnt <= r_dcnt + 1'b1;
                end
                ST_CWR: begin
                    if (pair_end) begin
                        r_d     <= '0;
                        r_t     <= '0;
                        r_found <= 1'b0;
                    end else if (pair_last_t) begin
                        r_t <= '0;
                        r_d <= r_d + 1'b1;
                    end else begin
                        r_t <= r_t + 1'b1;
                    end
                end
                ST_SRD: begin
                    if (skip) begin
                        if (pair_last_t) begin
                            r_t <= '0;
                            r_d <= r_d + 1'b1;
                        end else begin
                            r_t <= r_t + 1'b1;
                        end
                    end
                end
                ST_SCMP: begin
                    // strict compare keeps the earliest pair on ties
                    if (!r_found || ovl_q > r_bv) begin
                        r_found <= 1'b1;
                        r_bd    <= r_d[IDX_W-1:0];
                        r_bt    <= r_t[IDX_W-1:0];
                        r_bv    <= ovl_q;
                    end
                    if (pair_last_t) begin
                        r_t <= '0;
                        r_d <= r_d + 1'b1;
                    end else begin
                        r_t <= r_t + 1'b1;
                    end
                end
                ST_SDEC: begin
                    if (!is_match || can_put) begin
                        r_d     <= '0;
                        r_t     <= '0;
                        r_found <= 1'b0;
                    end
                    if (is_match && can_put) begin
                        r_det_used[r_bd] <= 1'b1;
                        r_trk_used[r_bt] <= 1'b1;
                    end
                end
                ST_UDET: begin
                    if (r_d < (IDX_W+1)'(r_det_cnt)
                        && (r_det_used[r_d[IDX_W-1:0]] || can_put)) begin
                        r_d <= r_d + 1'b1;
                    end
                end
                ST_UTRK: begin
                    if (r_t < (IDX_W+1)'(r_trk_cnt)
                        && (r_trk_used[r_t[IDX_W-1:0]] || can_put)) begin
                        r_t <= r_t + 1'b1;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_pend_v   <= 1'b0;
                        r_det_cnt  <= '0;
                        r_trk_cnt  <= '0;
                        r_det_used <= '0;
                        r_trk_used <= '0;
                        r_drop     <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;
    assign o_last  = r_out_last;
endmodule
